// ===== rtl/sorted_date_table_unit_macros.svh =====
// Assertion helpers; clocked on clock, disabled while reset is high.
`ifndef SORTED_DATE_TABLE_UNIT_MACROS_SVH
`define SORTED_DATE_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define SDT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sdt_pkg.sv =====
`timescale 1ns / 1ps
package sdt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
   localparam int TAG_W   = 16;
   localparam int POS_W   = 7;
   localparam int PAIRS_W = 11;

   localparam logic [PAIRS_W-1:0] PAIR_MAX = '1;

   localparam int GROUP_SIZE = 8;
   localparam int GROUP_BITS = 3;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_ENC,
      ST_FIN
   } state_type;

   // per-cell compare result against the pending request key
   typedef struct packed {
      logic lt;
      logic le;
      logic eq;
   } cell_flags_type;

   // boundaries found within one group of cells
   typedef struct packed {
      logic                  any_gt;
      logic [GROUP_BITS-1:0] gt_idx;
      logic                  any_ge;
      logic [GROUP_BITS-1:0] ge_idx;
      logic                  found;
      logic [TAG_W-1:0]      tag;
   } grp_result_type;

endpackage

// ===== rtl/sorted_date_table_unit.sv =====
`timescale 1ns / 1ps
`include "sorted_date_table_unit_macros.svh"
// Sorted date table: a chain of TABLE_DEPTH cells, each holding one date with its
// record tag, kept ascending by year, month, day; an insert lands after all equal
// dates. Pulse start while busy is low; once a request is accepted, its result
// shows on the rsp_ ports for one cycle with rsp_strobe high and cannot be held
// off. The four steps are: register the request, compare it in every cell at once,
// encode the insert and search boundaries in groups of eight cells, then combine
// the groups, shift the chain on insert and register the result. A new request
// may be started in the cycle the result is shown. No clearing pass is needed
// after reset; cells past the entry count are ignored.
module sorted_date_table_unit #(
   parameter int TABLE_DEPTH = sdt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [sdt_pkg::DAY_W-1:0]     req_day,
   input  logic [sdt_pkg::MONTH_W-1:0]   req_month,
   input  logic [sdt_pkg::YEAR_W-1:0]    req_year,
   input  logic [sdt_pkg::TAG_W-1:0]     req_record_tag,
   output logic                          rsp_strobe,
   output logic                          rsp_found,
   output logic [sdt_pkg::POS_W-1:0]     rsp_position,
   output logic [sdt_pkg::TAG_W-1:0]     rsp_match_tag,
   output logic [sdt_pkg::POS_W-1:0]     rsp_entry_count,
   output logic [sdt_pkg::PAIRS_W-1:0]   rsp_duplicate_pairs,
   output logic                          rsp_full_reject
);
   import sdt_pkg::*;

   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
   localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int SUM_W      = ((CNT_W > PAIRS_W) ? CNT_W : PAIRS_W) + 1;

   state_type state_ff, state_in;

   logic             cmd_ff;
   logic [KEY_W-1:0] key_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PAIRS_W-1:0] pairs_ff, pairs_in;

   logic               strobe_ff;
   logic               found_ff, found_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [TAG_W-1:0]   match_tag_ff, match_tag_in;
   logic               reject_ff, reject_in;

   logic accept;
   logic cmp_en;
   logic shift_en;
   logic finish;

   logic           [TABLE_DEPTH-1:0] cell_valid;
   logic           [TABLE_DEPTH-1:0][KEY_W-1:0] cell_key;
   logic           [TABLE_DEPTH-1:0][TAG_W-1:0] cell_tag;
   cell_flags_type [TABLE_DEPTH-1:0] cell_flags;
   grp_result_type [NUM_GROUPS-1:0]  grp_res;

   logic [CNT_W-1:0] upper;
   logic [CNT_W-1:0] lower;
   logic [SUM_W-1:0] pair_sum;
   logic             table_full;

   // chain of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign cell_valid[i] = (count_ff > CNT_W'(i));
      if (i == 0) begin : g_head
         sdt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmp_en     (cmp_en),
            .shift_en   (shift_en),
            .cell_valid (cell_valid[i]),
            .new_key    (key_ff),
            .new_tag    (tag_ff),
            .left_key   (key_ff),
            .left_tag   (tag_ff),
            .left_le    (1'b1),
            .key        (cell_key[i]),
            .tag        (cell_tag[i]),
            .flags      (cell_flags[i])
         );
      end else begin : g_body
         sdt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmp_en     (cmp_en),
            .shift_en   (shift_en),
            .cell_valid (cell_valid[i]),
            .new_key    (key_ff),
            .new_tag    (tag_ff),
            .left_key   (cell_key[i-1]),
            .left_tag   (cell_tag[i-1]),
            .left_le    (cell_flags[i-1].le),
            .key        (cell_key[i]),
            .tag        (cell_tag[i]),
            .flags      (cell_flags[i])
         );
      end
   end

   // boundary encoders, one per group of cells; pad slots never form a boundary
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
      cell_flags_type [GROUP_SIZE-1:0]         gflags;
      logic [GROUP_SIZE-1:0][TAG_W-1:0]        gtags;
      logic                                    gleft_lt;
      logic                                    gleft_le;

      for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_slot
         if (g * GROUP_SIZE + k < TABLE_DEPTH) begin : g_real
            assign gflags[k] = cell_flags[g * GROUP_SIZE + k];
            assign gtags[k]  = cell_tag[g * GROUP_SIZE + k];
         end else begin : g_pad
            assign gflags[k] = '{lt: 1'b1, le: 1'b1, eq: 1'b0};
            assign gtags[k]  = '0;
         end
      end

      if (g == 0) begin : g_first
         assign gleft_lt = 1'b1;
         assign gleft_le = 1'b1;
      end else begin : g_next
         assign gleft_lt = cell_flags[g * GROUP_SIZE - 1].lt;
         assign gleft_le = cell_flags[g * GROUP_SIZE - 1].le;
      end

      sdt_group u_group (
         .clock   (clock),
         .reset   (reset),
         .flags   (gflags),
         .tags    (gtags),
         .left_lt (gleft_lt),
         .left_le (gleft_le),
         .result  (grp_res[g])
      );
   end

   // combine groups; with no boundary the point lies at the entry count
   always_comb begin
      logic             hit_gt;
      logic             hit_ge;
      logic [CNT_W-1:0] enc_gt;
      logic [CNT_W-1:0] enc_ge;
      logic             any_found;
      logic [TAG_W-1:0] any_tag;
      hit_gt    = 1'b0;
      hit_ge    = 1'b0;
      enc_gt    = '0;
      enc_ge    = '0;
      any_found = 1'b0;
      any_tag   = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (grp_res[g].any_gt) begin
            hit_gt = 1'b1;
            enc_gt = enc_gt | CNT_W'(g * GROUP_SIZE + int'(grp_res[g].gt_idx));
         end
         if (grp_res[g].any_ge) begin
            hit_ge = 1'b1;
            enc_ge = enc_ge | CNT_W'(g * GROUP_SIZE + int'(grp_res[g].ge_idx));
         end
         if (grp_res[g].found) begin
            any_found = 1'b1;
            any_tag   = any_tag | grp_res[g].tag;
         end
      end
      upper      = hit_gt ? enc_gt : count_ff;
      lower      = hit_ge ? enc_ge : count_ff;
      table_full = (count_ff == CNT_W'(TABLE_DEPTH));
      pair_sum   = SUM_W'(pairs_ff) + SUM_W'(upper - lower);

      count_in     = count_ff;
      pairs_in     = pairs_ff;
      found_in     = 1'b0;
      position_in  = '0;
      match_tag_in = '0;
      reject_in    = 1'b0;
      if (cmd_ff == CMD_SEARCH) begin
         found_in     = any_found;
         position_in  = POS_W'(lower);
         match_tag_in = any_tag;
      end else if (table_full) begin
         reject_in = 1'b1;
      end else begin
         count_in    = count_ff + 1'b1;
         position_in = POS_W'(upper);
         pairs_in    = (pair_sum > SUM_W'(PAIR_MAX)) ? PAIR_MAX : pair_sum[PAIRS_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      accept   = 1'b0;
      cmp_en   = 1'b0;
      finish   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               accept   = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmp_en   = 1'b1;
            state_in = ST_ENC;
         end
         ST_ENC: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            finish   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign shift_en = finish && (cmd_ff == CMD_INSERT) && !table_full;
   assign busy     = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         pairs_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= finish;
         if (finish) begin
            count_ff <= count_in;
            pairs_ff <= pairs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         key_ff <= {req_year, req_month, req_day};
         tag_ff <= req_record_tag;
      end
      if (finish) begin
         found_ff     <= found_in;
         position_ff  <= position_in;
         match_tag_ff <= match_tag_in;
         reject_ff    <= reject_in;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_found           = found_ff;
   assign rsp_position        = position_ff;
   assign rsp_match_tag       = match_tag_ff;
   assign rsp_entry_count     = POS_W'(count_ff);
   assign rsp_duplicate_pairs = pairs_ff;
   assign rsp_full_reject     = reject_ff;

   `SDT_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "entry count above depth")
   `SDT_ASSERT_NXT(a_fin_strobe, state_ff == ST_FIN, rsp_strobe && !busy, "result not shown after finish")
   `SDT_ASSERT_IMP(a_reject_full, rsp_strobe && rsp_full_reject, count_ff == CNT_W'(TABLE_DEPTH), "reject while table not full")
   `SDT_ASSERT_NXT(a_insert_count, shift_en, count_ff == $past(count_ff) + 1'b1, "insert did not advance count")

endmodule

// ===== rtl/sdt_cell.sv =====
`timescale 1ns / 1ps
module sdt_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmp_en,
   input  logic                       shift_en,
   input  logic                       cell_valid,
   input  logic [sdt_pkg::KEY_W-1:0]  new_key,
   input  logic [sdt_pkg::TAG_W-1:0]  new_tag,
   input  logic [sdt_pkg::KEY_W-1:0]  left_key,
   input  logic [sdt_pkg::TAG_W-1:0]  left_tag,
   input  logic                       left_le,
   output logic [sdt_pkg::KEY_W-1:0]  key,
   output logic [sdt_pkg::TAG_W-1:0]  tag,
   output sdt_pkg::cell_flags_type    flags
);
   import sdt_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   cell_flags_type   flags_ff, flags_in;

   always_comb begin
      flags_in.lt = cell_valid && (key_ff <  new_key);
      flags_in.le = cell_valid && (key_ff <= new_key);
      flags_in.eq = cell_valid && (key_ff == new_key);
      // first cell above the insert point takes the new entry, the rest move right
      key_in = left_le ? new_key : left_key;
      tag_in = left_le ? new_tag : left_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (cmp_en) begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en && !flags_ff.le) begin
         key_ff <= key_in;
         tag_ff <= tag_in;
      end
   end

   assign key   = key_ff;
   assign tag   = tag_ff;
   assign flags = flags_ff;

endmodule

// ===== rtl/sdt_group.sv =====
`timescale 1ns / 1ps
module sdt_group (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  sdt_pkg::cell_flags_type [sdt_pkg::GROUP_SIZE-1:0]     flags,
   input  logic [sdt_pkg::GROUP_SIZE-1:0][sdt_pkg::TAG_W-1:0]    tags,
   input  logic                                                  left_lt,
   input  logic                                                  left_le,
   output sdt_pkg::grp_result_type                               result
);
   import sdt_pkg::*;

   grp_result_type res_ff, res_in;

   always_comb begin
      logic prev_lt;
      logic prev_le;
      res_in = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
         prev_lt = (k == 0) ? left_lt : flags[k-1].lt;
         prev_le = (k == 0) ? left_le : flags[k-1].le;
         if (!flags[k].le && prev_le) begin
            res_in.any_gt = 1'b1;
            res_in.gt_idx = res_in.gt_idx | GROUP_BITS'(k);
         end
         if (!flags[k].lt && prev_lt) begin
            res_in.any_ge = 1'b1;
            res_in.ge_idx = res_in.ge_idx | GROUP_BITS'(k);
            if (flags[k].eq) begin
               res_in.found = 1'b1;
               res_in.tag   = tags[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule
